### sv/drca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drca_pkg
// Shared types, constants and the bucket bound stepping function.
// ----------------------------------------------------------------------------
package drca_pkg;

  localparam int unsigned MaxBuckets = 64;
  localparam int unsigned BktW       = 6;
  localparam int unsigned ColW       = 10;
  localparam int unsigned DepthW     = 16;
  localparam int unsigned SumW       = 28;
  localparam int unsigned CntW       = 7;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 10;

  localparam logic [CfgAddrW-1:0] RegBucketCount = 3'd0;
  localparam logic [CfgAddrW-1:0] RegImageWidth  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegDriveRowA   = 3'd2;
  localparam logic [CfgAddrW-1:0] RegDriveRowB   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegDriveRowC   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegRecoverRowA = 3'd5;
  localparam logic [CfgAddrW-1:0] RegRecoverRowB = 3'd6;
  localparam logic [CfgAddrW-1:0] RegRecoverRowC = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR, S_DIVS, S_DIVC, S_WALK, S_IDLE, S_ACC,
    S_ERD, S_EDIV, S_EWAIT, S_EOUT
  } state_e;

  typedef struct packed {
    logic [ColW-1:0] bnd;
    logic [7:0]      rem;
  } bound_t;

  // One bucket forward: the numerator grows by 2W = 2C*q + rm2.
  function automatic bound_t bound_step(input bound_t cur, input logic [ColW-1:0] q,
                                        input logic [7:0] rm2, input logic [7:0] c2);
    bound_t     nxt;
    logic [8:0] s;
    logic       carry;
    s       = {1'b0, cur.rem} + {1'b0, rm2};
    carry   = (s >= {1'b0, c2});
    nxt.bnd = cur.bnd + q + {{(ColW-1){1'b0}}, carry};
    nxt.rem = carry ? 8'(s - {1'b0, c2}) : s[7:0];
    return nxt;
  endfunction

endpackage
`default_nettype wire

### sv/drca_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drca_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module drca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### sv/drca_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drca_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drca_div #(
  parameter int unsigned NumW = 28,
  parameter int unsigned DenW = 12
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quot_o,
  output logic      [DenW-1:0] rem_o
);
  localparam int unsigned CW = $clog2(NumW + 1);

  logic [CW-1:0]   cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DenW:0]   r_sh;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    r_sh  = {rem_q, quo_q[NumW-1]};
    if (start_i) begin
      cnt_d = CW'(NumW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (r_sh >= {1'b0, den_q}) begin
        rem_d = DenW'(r_sh - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = r_sh[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### sv/depth_row_column_bin_averager_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_row_column_bin_averager_core
// Per-bucket averages of depth over driving and recovery rows of a frame.
// ----------------------------------------------------------------------------
// Pixel path: a pixel word is read from the one sum memory, then added and
// written back; input is stalled meanwhile, so a new pixel is not taken until
// the last is written. At frame end each bucket result comes from the 28-bit
// bit-serial dividers, one bucket at a time, and the emit waits on out_stall_i.
// Reset: a clearing pass zeroes all 64 entries of the sum memory, then bound
// setup walks the bounds up to the current bucket; input is stalled until
// done. A configuration write repeats the bound setup.
// ----------------------------------------------------------------------------
module depth_row_column_bin_averager_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [drca_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [drca_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [drca_pkg::DepthW-1:0]    depth_i,
  input  wire logic                           frame_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [drca_pkg::BktW-1:0]      bucket_index_o,
  output logic      [drca_pkg::DepthW-1:0]    drive_average_o,
  output logic      [drca_pkg::DepthW-1:0]    recover_average_o,
  output logic                                last_bucket_o
);
  import drca_pkg::*;

  // Configuration registers.
  logic [6:0]      bc_q;
  logic [ColW-1:0] iw_q, dra_q, drb_q, drc_q, rra_q, rrb_q, rrc_q;

  state_e state_q, state_d;

  logic [ColW-1:0] col_q, col_d, row_q, row_d;
  logic [BktW-1:0] bkt_q, bkt_d;
  bound_t          bnd_q, bnd_d, b1_q, b1_d;
  logic [ColW-1:0] q_q, q_d;
  logic [7:0]      rm2_q, rm2_d;
  logic [CntW-1:0] wj_q, wj_d, clr_q, clr_d;
  logic            pend_q, pend_d;
  logic [BktW-1:0] ek_q, ek_d;
  logic [11:0]     ediv_q, ediv_d;
  logic            ezero_q, ezero_d;
  logic [BktW-1:0] ak_q, ak_d;
  logic [17:0]     dadd_q, dadd_d, radd_q, radd_d;
  logic            fe_q, fe_d;

  logic            ov_q, ov_d, olast_q, olast_d;
  logic [BktW-1:0] oidx_q, oidx_d;
  logic [DepthW-1:0] oda_q, oda_d, ora_q, ora_d;

  // Effective count and width after the out-of-range rules.
  logic [CntW-1:0] ceff;
  logic [ColW-1:0] weff;
  logic [7:0]      c2;
  logic [BktW-1:0] cm1;
  bound_t          stepped, bnd0;

  always_comb begin
    if (bc_q == '0) begin
      ceff = 7'd1;
    end else if (bc_q > 7'(MaxBuckets)) begin
      ceff = 7'(MaxBuckets);
    end else begin
      ceff = bc_q;
    end
    weff     = (iw_q == '0) ? 10'd1 : iw_q;
    c2       = {ceff, 1'b0};
    cm1      = BktW'(ceff - 7'd1);
    stepped  = bound_step(bnd_q, q_q, rm2_q, c2);
    bnd0.bnd = '0;
    bnd0.rem = {1'b0, ceff};
  end

  // Sum memory: drive sum in the upper half, recovery sum in the lower.
  logic                  ram_we;
  logic [BktW-1:0]       ram_waddr, ram_raddr;
  logic [2*SumW-1:0]     ram_wdata, ram_rdata;

  drca_ram #(.Width(2*SumW), .Depth(MaxBuckets)) u_sums (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Width divided by count, for the bound stepping.
  logic            cdiv_start, cdiv_done;
  logic [ColW-1:0] cdiv_quot;
  logic [CntW-1:0] cdiv_rem;

  drca_div #(.NumW(ColW), .DenW(CntW)) u_cfg_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cdiv_start),
    .num_i  (weff),
    .den_i  (ceff),
    .done_o (cdiv_done),
    .quot_o (cdiv_quot),
    .rem_o  (cdiv_rem)
  );

  // Average dividers, one per sum.
  logic            adiv_start, ddiv_done, rdiv_done;
  logic [SumW-1:0] ddiv_quot, rdiv_quot;
  logic [11:0]     ddiv_rem, rdiv_rem;

  drca_div #(.NumW(SumW), .DenW(12)) u_drive_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(adiv_start),
    .num_i  (ram_rdata[2*SumW-1:SumW]),
    .den_i  (ediv_q),
    .done_o (ddiv_done),
    .quot_o (ddiv_quot),
    .rem_o  (ddiv_rem)
  );

  drca_div #(.NumW(SumW), .DenW(12)) u_recover_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(adiv_start),
    .num_i  (ram_rdata[SumW-1:0]),
    .den_i  (ediv_q),
    .done_o (rdiv_done),
    .quot_o (rdiv_quot),
    .rem_o  (rdiv_rem)
  );

  // Remainders of the average division are not needed.
  logic unused_rem;
  assign unused_rem = ^{ddiv_rem, rdiv_rem};

  logic        adv, accept, out_take;
  logic [BktW-1:0] k_now;
  logic [1:0]  nd, nr;
  logic [ColW-1:0] col_inc;
  logic [SumW:0] dsum, rsum;
  logic [ColW-1:0] ew;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    bkt_d   = bkt_q;
    bnd_d   = bnd_q;
    b1_d    = b1_q;
    q_d     = q_q;
    rm2_d   = rm2_q;
    wj_d    = wj_q;
    clr_d   = clr_q;
    pend_d  = pend_q;
    ek_d    = ek_q;
    ediv_d  = ediv_q;
    ezero_d = ezero_q;
    ak_d    = ak_q;
    dadd_d  = dadd_q;
    radd_d  = radd_q;
    fe_d    = fe_q;
    ov_d    = ov_q;
    olast_d = olast_q;
    oidx_d  = oidx_q;
    oda_d   = oda_q;
    ora_d   = ora_q;

    ram_we     = 1'b0;
    ram_waddr  = ak_q;
    ram_wdata  = '0;
    ram_raddr  = ek_q;
    cdiv_start = 1'b0;
    adiv_start = 1'b0;

    accept   = in_valid_i && (state_q == S_IDLE);
    out_take = ov_q && !out_stall_i;
    if (out_take) begin
      ov_d = 1'b0;
    end

    adv   = (col_q >= bnd_q.bnd) && (bkt_q < cm1);
    k_now = adv ? bkt_q + 1'b1 : bkt_q;
    nd    = 2'((row_q == dra_q)) + 2'((row_q == drb_q)) + 2'((row_q == drc_q));
    nr    = 2'((row_q == rra_q)) + 2'((row_q == rrb_q)) + 2'((row_q == rrc_q));
    col_inc = col_q + 1'b1;
    dsum  = {1'b0, ram_rdata[2*SumW-1:SumW]} + (SumW+1)'(dadd_q);
    rsum  = {1'b0, ram_rdata[SumW-1:0]} + (SumW+1)'(radd_q);
    ew    = stepped.bnd - bnd_q.bnd;

    unique case (state_q)
      S_CLEAR: begin
        // One entry of the sum memory zeroed each cycle.
        ram_we    = 1'b1;
        ram_waddr = clr_q[BktW-1:0];
        clr_d     = clr_q + 1'b1;
        if (clr_q == CntW'(MaxBuckets - 1)) begin
          state_d = pend_q ? S_DIVS : S_IDLE;
          pend_d  = 1'b0;
        end
      end
      S_DIVS: begin
        cdiv_start = 1'b1;
        if (bkt_q > cm1) begin
          bkt_d = cm1;
        end
        state_d = S_DIVC;
      end
      S_DIVC: begin
        if (cdiv_done) begin
          q_d     = cdiv_quot;
          rm2_d   = {cdiv_rem, 1'b0};
          bnd_d   = bnd0;
          wj_d    = '0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // Walk the bounds from bucket zero up to the current bucket.
        bnd_d = stepped;
        wj_d  = wj_q + 1'b1;
        if (wj_q == '0) begin
          b1_d = stepped;
        end
        if (wj_q == CntW'(bkt_q)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = k_now;
        if (accept) begin
          ak_d   = k_now;
          dadd_d = 18'(depth_i) * 18'(nd);
          radd_d = 18'(depth_i) * 18'(nr);
          fe_d   = frame_end_i;
          if (col_inc >= weff) begin
            col_d = '0;
            row_d = row_q + 1'b1;
            bkt_d = '0;
            bnd_d = b1_q;
          end else begin
            col_d = col_inc;
            bkt_d = k_now;
            if (adv) begin
              bnd_d = stepped;
            end
          end
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        ram_we    = 1'b1;
        ram_waddr = ak_q;
        ram_wdata = {dsum[SumW] ? {SumW{1'b1}} : dsum[SumW-1:0],
                     rsum[SumW] ? {SumW{1'b1}} : rsum[SumW-1:0]};
        if (fe_q) begin
          ek_d    = '0;
          bnd_d   = bnd0;
          state_d = S_ERD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ERD: begin
        ram_raddr = ek_q;
        bnd_d     = stepped;
        ezero_d   = (ew == '0);
        ediv_d    = {1'b0, ew, 1'b0} + {2'b00, ew};
        state_d   = S_EDIV;
      end
      S_EDIV: begin
        // Data of the bucket is in hand: start dividing and zero the entry.
        adiv_start = 1'b1;
        ram_we     = 1'b1;
        ram_waddr  = ek_q;
        state_d    = S_EWAIT;
      end
      S_EWAIT: begin
        if (ddiv_done && rdiv_done) begin
          state_d = S_EOUT;
        end
      end
      S_EOUT: begin
        if (!ov_q || out_take) begin
          ov_d    = 1'b1;
          oidx_d  = ek_q;
          olast_d = (ek_q == cm1);
          if (ezero_q) begin
            oda_d = '0;
            ora_d = '0;
          end else begin
            oda_d = (|ddiv_quot[SumW-1:DepthW]) ? {DepthW{1'b1}} : ddiv_quot[DepthW-1:0];
            ora_d = (|rdiv_quot[SumW-1:DepthW]) ? {DepthW{1'b1}} : rdiv_quot[DepthW-1:0];
          end
          if (ek_q == cm1) begin
            col_d = '0;
            row_d = '0;
            bkt_d = '0;
            bnd_d = b1_q;
            clr_d = ceff;
            // Entries beyond the bucket count still need clearing.
            state_d = (ceff == CntW'(MaxBuckets)) ? S_IDLE : S_CLEAR;
          end else begin
            ek_d    = ek_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A configuration write reruns the bound setup; during a clearing pass
    // it is held until the pass ends.
    if (cfg_we_i) begin
      if (state_q == S_CLEAR || state_d == S_CLEAR) begin
        pend_d = 1'b1;
      end else begin
        state_d = S_DIVS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      bc_q    <= 7'd64;
      iw_q    <= 10'd640;
      dra_q   <= 10'd100;
      drb_q   <= 10'd125;
      drc_q   <= 10'd150;
      rra_q   <= 10'd179;
      rrb_q   <= 10'd180;
      rrc_q   <= 10'd181;
      col_q   <= '0;
      row_q   <= '0;
      bkt_q   <= '0;
      bnd_q   <= '0;
      b1_q    <= '0;
      q_q     <= '0;
      rm2_q   <= '0;
      wj_q    <= '0;
      clr_q   <= '0;
      pend_q  <= 1'b1;
      ek_q    <= '0;
      fe_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      bkt_q   <= bkt_d;
      bnd_q   <= bnd_d;
      b1_q    <= b1_d;
      q_q     <= q_d;
      rm2_q   <= rm2_d;
      wj_q    <= wj_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      ek_q    <= ek_d;
      fe_q    <= fe_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegBucketCount: bc_q  <= cfg_wdata_i[6:0];
          RegImageWidth:  iw_q  <= cfg_wdata_i;
          RegDriveRowA:   dra_q <= cfg_wdata_i;
          RegDriveRowB:   drb_q <= cfg_wdata_i;
          RegDriveRowC:   drc_q <= cfg_wdata_i;
          RegRecoverRowA: rra_q <= cfg_wdata_i;
          RegRecoverRowB: rrb_q <= cfg_wdata_i;
          RegRecoverRowC: rrc_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ediv_q  <= ediv_d;
    ezero_q <= ezero_d;
    ak_q    <= ak_d;
    dadd_q  <= dadd_d;
    radd_q  <= radd_d;
    olast_q <= olast_d;
    oidx_q  <= oidx_d;
    oda_q   <= oda_d;
    ora_q   <= ora_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = ov_q;
  assign bucket_index_o    = oidx_q;
  assign drive_average_o   = oda_q;
  assign recover_average_o = ora_q;
  assign last_bucket_o     = olast_q;
endmodule
`default_nettype wire

### sim/depth_row_column_bin_averager_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_row_column_bin_averager_core_tb
// Drives depth pixel words and register writes into the bin averager. It
// mirrors the bucket sums in a local predictor and checks every per-bucket
// average word against it in order, under random idling and stalling.
// ----------------------------------------------------------------------------
module depth_row_column_bin_averager_core_tb;
  import drca_pkg::*;

  typedef struct {
    logic [BktW-1:0]   bucket;
    logic [DepthW-1:0] drive_avg;
    logic [DepthW-1:0] recover_avg;
    logic              last;
  } bucket_avg_t;

  localparam int unsigned SumMax = (1 << SumW) - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [DepthW-1:0]   depth_i = '0;
  logic                frame_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [BktW-1:0]     bucket_index_o;
  logic [DepthW-1:0]   drive_average_o;
  logic [DepthW-1:0]   recover_average_o;
  logic                last_bucket_o;

  depth_row_column_bin_averager_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .depth_i, .frame_end_i,
    .out_valid_o, .out_stall_i, .bucket_index_o, .drive_average_o,
    .recover_average_o, .last_bucket_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor copy of the registers and of the frame state.
  int unsigned bucket_count_reg, image_width_reg;
  int unsigned row_sel[8];
  int unsigned drive_acc[MaxBuckets], recover_acc[MaxBuckets];
  int unsigned col_now, row_now, bkt_now, bound_next;

  bucket_avg_t expected_avgs[$];
  int          fail_count = 0;
  int          pixels_sent = 0, avgs_checked = 0, frames_sent = 0;
  int          sender_idle_pct = 0, recv_stall_pct = 0;
  int          hold_off_req = 0;

  function automatic int unsigned eff_buckets();
    if (bucket_count_reg == 0) return 1;
    if (bucket_count_reg > MaxBuckets) return MaxBuckets;
    return bucket_count_reg;
  endfunction

  function automatic int unsigned eff_width();
    return (image_width_reg == 0) ? 1 : image_width_reg;
  endfunction

  // Rounded even split: bound k = floor((2kW + C) / 2C).
  function automatic int unsigned bucket_bound(int unsigned k);
    return (2 * k * eff_width() + eff_buckets()) / (2 * eff_buckets());
  endfunction

  function automatic void clear_frame_state();
    for (int i = 0; i < MaxBuckets; i++) begin
      drive_acc[i]   = 0;
      recover_acc[i] = 0;
    end
    col_now    = 0;
    row_now    = 0;
    bkt_now    = 0;
    bound_next = bucket_bound(1);
  endfunction

  function automatic void apply_register(logic [CfgAddrW-1:0] idx, int unsigned val);
    if (idx == RegBucketCount) bucket_count_reg = val & 'h7f;
    else if (idx == RegImageWidth) image_width_reg = val & 'h3ff;
    else row_sel[idx] = val & 'h3ff;
    if (bkt_now > eff_buckets() - 1) bkt_now = eff_buckets() - 1;
    bound_next = bucket_bound(bkt_now + 1);
  endfunction

  function automatic int unsigned add_saturated(int unsigned a, int unsigned b);
    return (a + b > SumMax) ? SumMax : a + b;
  endfunction

  // Accumulates one accepted pixel and, at frame end, queues the averages.
  function automatic void accumulate_pixel(int unsigned depth, bit frame_end);
    int unsigned nd, nr, c, bw, dv;
    bucket_avg_t r;
    c = eff_buckets();
    if (col_now >= bound_next && bkt_now < c - 1) begin
      bkt_now++;
      bound_next = bucket_bound(bkt_now + 1);
    end
    nd = (row_now == row_sel[RegDriveRowA]) + (row_now == row_sel[RegDriveRowB])
       + (row_now == row_sel[RegDriveRowC]);
    nr = (row_now == row_sel[RegRecoverRowA]) + (row_now == row_sel[RegRecoverRowB])
       + (row_now == row_sel[RegRecoverRowC]);
    drive_acc[bkt_now]   = add_saturated(drive_acc[bkt_now], depth * nd);
    recover_acc[bkt_now] = add_saturated(recover_acc[bkt_now], depth * nr);
    col_now++;
    if (col_now >= eff_width()) begin
      col_now    = 0;
      row_now    = (row_now + 1) & 'h3ff;
      bkt_now    = 0;
      bound_next = bucket_bound(1);
    end
    if (!frame_end) return;
    for (int unsigned k = 0; k < c; k++) begin
      bw = bucket_bound(k + 1) - bucket_bound(k);
      r.bucket      = k[BktW-1:0];
      r.drive_avg   = '0;
      r.recover_avg = '0;
      if (bw != 0) begin
        dv = drive_acc[k] / (3 * bw);
        r.drive_avg = (dv > 65535) ? 16'hffff : dv[DepthW-1:0];
        dv = recover_acc[k] / (3 * bw);
        r.recover_avg = (dv > 65535) ? 16'hffff : dv[DepthW-1:0];
      end
      r.last = (k == c - 1);
      expected_avgs = {expected_avgs, r};
    end
    frames_sent++;
    clear_frame_state();
  endfunction

  // Counts down a requested receiver hold-off, by one at each clock edge.
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_off_req > 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Result side: checks each accepted word and decides the next stall.
  always @(posedge clk_i) begin
    bucket_avg_t e;
    if (out_valid_o && !out_stall_i) begin
      avgs_checked++;
      if (expected_avgs.size() == 0) begin
        $error("unexpected result word, bucket %0d", bucket_index_o);
        fail_count++;
      end else begin
        e = expected_avgs.pop_front();
        if (bucket_index_o !== e.bucket) begin
          $error("bucket_index: expected %0d, got %0d", e.bucket, bucket_index_o);
          fail_count++;
        end
        if (drive_average_o !== e.drive_avg) begin
          $error("drive_average: expected %0d, got %0d", e.drive_avg, drive_average_o);
          fail_count++;
        end
        if (recover_average_o !== e.recover_avg) begin
          $error("recover_average: expected %0d, got %0d", e.recover_avg,
                 recover_average_o);
          fail_count++;
        end
        if (last_bucket_o !== e.last) begin
          $error("last_bucket: expected %0d, got %0d", e.last, last_bucket_o);
          fail_count++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_register(logic [CfgAddrW-1:0] idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_register(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_rows(int unsigned da, int unsigned db, int unsigned dc,
                          int unsigned ra, int unsigned rb, int unsigned rc);
    write_register(RegDriveRowA, da);
    write_register(RegDriveRowB, db);
    write_register(RegDriveRowC, dc);
    write_register(RegRecoverRowA, ra);
    write_register(RegRecoverRowB, rb);
    write_register(RegRecoverRowC, rc);
  endtask

  // Offers one pixel word, waits for acceptance, then maybe idles a while.
  task automatic send_pixel(int unsigned depth, bit frame_end);
    in_valid_i  <= 1'b1;
    depth_i     <= depth[DepthW-1:0];
    frame_end_i <= frame_end;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_pixel(depth, frame_end);
    pixels_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // Drops valid, then waits for all averages and for the block to settle,
  // so that a register write cannot land while a pixel is still in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_avgs.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic int unsigned random_depth();
    case ($urandom_range(5))
      0: return 0;
      1: return 16'hffff;
      default: return $urandom_range(16'hffff);
    endcase
  endfunction

  // Reset configuration; one short frame with both depth extremes.
  task automatic test_reset_config();
    send_pixel(16'hffff, 1'b0);
    send_pixel(0, 1'b0);
    send_pixel(16'h1234, 1'b1);
    settle();
  endtask

  // Bucket count 0 and width 0 act as 1; counts above the maximum clamp and
  // buckets of zero width report zero. Rows match several registers.
  task automatic test_register_extremes();
    write_register(RegBucketCount, 0);
    write_register(RegImageWidth, 0);
    set_rows(0, 0, 1, 2, 0, 5);
    for (int i = 0; i < 6; i++) send_pixel(random_depth(), i == 5);
    settle();
    write_register(RegBucketCount, 127);
    write_register(RegImageWidth, 3);
    for (int i = 0; i < 7; i++) send_pixel(random_depth(), i == 6);
    settle();
  endtask

  // A short row at maximum depth counted three times, then the driving rows
  // move under the running frame so that the average saturates.
  task automatic test_saturation();
    write_register(RegBucketCount, 1);
    write_register(RegImageWidth, 2);
    set_rows(0, 0, 0, 0, 1, 1);
    for (int i = 0; i < 2; i++) send_pixel(16'hffff, 1'b0);
    settle();
    set_rows(1, 1, 1, 0, 1, 1);
    for (int i = 0; i < 2; i++) send_pixel(16'hffff, i == 1);
    settle();
  endtask

  // Shrinking the bucket count in mid-frame clamps the current bucket.
  task automatic test_midframe_shrink();
    write_register(RegBucketCount, 16);
    write_register(RegImageWidth, 16);
    set_rows(0, 1, 0, 0, 0, 1);
    for (int i = 0; i < 10; i++) send_pixel(random_depth(), 1'b0);
    settle();
    write_register(RegBucketCount, 2);
    for (int i = 0; i < 6; i++) send_pixel(random_depth(), i == 5);
    settle();
  endtask

  // Small random frames under one idling mix; configuration changes between.
  task automatic test_random_frames(int idle_pct, int stall_pct, int n_pixels);
    int sent, len, w;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    sent = 0;
    while (sent < n_pixels) begin
      w = $urandom_range(12, 1);
      write_register(RegImageWidth, w);
      write_register(RegBucketCount, ($urandom_range(4) == 0) ? 64 : $urandom_range(w + 2, 1));
      set_rows($urandom_range(3), $urandom_range(3), $urandom_range(4),
               $urandom_range(3), $urandom_range(4), $urandom_range(2));
      len = $urandom_range(8, 3);
      for (int i = 0; i < len; i++) send_pixel(random_depth(), i == len - 1);
      sent += len;
      settle();
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so
  // the emit phase backs up and the block stalls its pixel input.
  task automatic test_backpressure();
    write_register(RegBucketCount, 16);
    write_register(RegImageWidth, 4);
    set_rows(0, 1, 2, 1, 2, 3);
    hold_off_req = 400;
    for (int f = 0; f < 3; f++)
      for (int i = 0; i < 8; i++) send_pixel(random_depth(), i == 7);
    settle();
  endtask

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    bucket_count_reg = 64;
    image_width_reg  = 640;
    row_sel[RegDriveRowA]   = 100;
    row_sel[RegDriveRowB]   = 125;
    row_sel[RegDriveRowC]   = 150;
    row_sel[RegRecoverRowA] = 179;
    row_sel[RegRecoverRowB] = 180;
    row_sel[RegRecoverRowC] = 181;
    clear_frame_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Let the clearing pass and bound setup finish before any write.
    repeat (200) @(posedge clk_i);

    test_reset_config();
    test_register_extremes();
    test_saturation();
    test_midframe_shrink();
    test_random_frames(0, 0, 10);
    test_random_frames(53, 0, 10);
    test_random_frames(0, 53, 10);
    test_random_frames(14, 14, 10);
    test_backpressure();

    $display("Sent %0d pixel words in %0d frames; checked %0d bucket average words.",
             pixels_sent, frames_sent, avgs_checked);
    $display("Covered register extremes, average saturation, mid-frame changes, stalls.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
